// File: hdl/balu_pkg.sv
// Shared command codes, flag positions and controller/datapath types for the byte ALU.
`default_nettype none

package balu_pkg;

   localparam int NUM_REGS_DEFAULT  = 8;
   localparam int MEM_DEPTH_DEFAULT = 256;

   localparam logic [3:0] CMD_READ   = 4'd0;
   localparam logic [3:0] CMD_MOVE   = 4'd1;
   localparam logic [3:0] CMD_ADD    = 4'd2;
   localparam logic [3:0] CMD_SUB    = 4'd3;
   localparam logic [3:0] CMD_MUL    = 4'd4;
   localparam logic [3:0] CMD_DIV    = 4'd5;
   localparam logic [3:0] CMD_AND    = 4'd6;
   localparam logic [3:0] CMD_OR     = 4'd7;
   localparam logic [3:0] CMD_XOR    = 4'd8;
   localparam logic [3:0] CMD_XNOR   = 4'd9;
   localparam logic [3:0] CMD_NEGATE = 4'd10;
   localparam logic [3:0] CMD_SHIFT  = 4'd11;
   localparam logic [3:0] CMD_COUNT  = 4'd12;
   localparam logic [3:0] CMD_LOAD   = 4'd13;
   localparam logic [3:0] CMD_SAVE   = 4'd14;

   localparam int FLAG_CARRY  = 0;
   localparam int FLAG_ZERO   = 1;
   localparam int FLAG_PARITY = 2;

   localparam logic [7:0] BYTE_MAX = 8'hFF;

   // restoring divider: one quotient bit per step
   localparam int DIV_STEPS = 8;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic capture;   // transfer accepted: latch fields, launch reads
      logic exec;      // decode and compute the command
      logic div_step;  // one restoring division step
      logic commit;    // write back state and load the result register
   } balu_cmd_type;

endpackage

`default_nettype wire

// File: hdl/byte_alu_with_register_file_unit.sv
// Top level of the byte ALU: sequencer plus datapath behind request and response channels.
`default_nettype none

// Byte ALU working on a NUM_REGS-entry register file and a MEM_DEPTH-byte data
// memory. Each request transfer carries one command and yields exactly one
// response transfer with the target register after the command, the flags
// (bit 0 carry, bit 1 zero, bit 2 even parity), the remainder register and a
// division error mark. Items are handled one at a time: a request passes from
// transfer to a loaded response through register and memory read, execute and
// write back, and a division with a nonzero divisor runs the restoring divider
// between execute and write back, producing one quotient bit per cycle. A new
// request is taken as soon as the previous one has been written back, even while
// its response still waits in the output register; write back waits only if that
// register is still occupied. The register file clears at reset through
// per-entry valid bits; the data memory is not cleared, so a load of a byte never
// saved returns an arbitrary value. Register indexes at or above NUM_REGS read as
// zero and ignore writes; memory addresses at or above MEM_DEPTH load zero and
// ignore saves.
module byte_alu_with_register_file_unit
   import balu_pkg::*;
#(
   parameter int NUM_REGS  = NUM_REGS_DEFAULT,
   parameter int MEM_DEPTH = MEM_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_command,
   input  logic [2:0]  req_target_reg,
   input  logic [2:0]  req_source_reg,
   input  logic        req_use_source,
   input  logic [7:0]  req_immediate_value,
   input  logic        req_direction,
   input  logic [7:0]  req_shift_amount,
   input  logic [7:0]  req_mem_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_value,
   output logic [2:0]  rsp_flag_bits,
   output logic [15:0] rsp_remainder_out,
   output logic        rsp_div_error
);

   balu_cmd_type cmd;       // per-cycle commands from the sequencer
   logic         need_div;  // decoded divide with a nonzero divisor

   balu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .need_div  (need_div),
      .cmd       (cmd)
   );

   balu_dpath #(
      .NUM_REGS  (NUM_REGS),
      .MEM_DEPTH (MEM_DEPTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .need_div            (need_div),
      .req_command         (req_command),
      .req_target_reg      (req_target_reg),
      .req_source_reg      (req_source_reg),
      .req_use_source      (req_use_source),
      .req_immediate_value (req_immediate_value),
      .req_direction       (req_direction),
      .req_shift_amount    (req_shift_amount),
      .req_mem_address     (req_mem_address),
      .rsp_value           (rsp_value),
      .rsp_flag_bits       (rsp_flag_bits),
      .rsp_remainder_out   (rsp_remainder_out),
      .rsp_div_error       (rsp_div_error)
   );

endmodule

`default_nettype wire

// File: hdl/balu_ctrl.sv
// Sequencer for the byte ALU: transfer handshake, division step count and commit timing.
`default_nettype none

module balu_ctrl
   import balu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  logic         need_div,
   output balu_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_WB   = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = need_div ? S_DIV : S_WB;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               div_cnt_in = '0;
               state_in   = S_WB;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_WB: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EXEC))
      else $error("accepted transfer did not move to execute");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DIV) |-> (div_cnt_ff == '0))
      else $error("division counter running outside divide state");
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit overwrote a pending result");
   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result valid raised without a commit");
`endif

endmodule

`default_nettype wire

// File: hdl/balu_dpath.sv
// Datapath for the byte ALU: register file, data memory, ALU, divider and result register.
`default_nettype none

module balu_dpath
   import balu_pkg::*;
#(
   parameter int NUM_REGS  = NUM_REGS_DEFAULT,
   parameter int MEM_DEPTH = MEM_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  balu_cmd_type cmd,
   output logic         need_div,
   input  logic [3:0]   req_command,
   input  logic [2:0]   req_target_reg,
   input  logic [2:0]   req_source_reg,
   input  logic         req_use_source,
   input  logic [7:0]   req_immediate_value,
   input  logic         req_direction,
   input  logic [7:0]   req_shift_amount,
   input  logic [7:0]   req_mem_address,
   output logic [7:0]   rsp_value,
   output logic [2:0]   rsp_flag_bits,
   output logic [15:0]  rsp_remainder_out,
   output logic         rsp_div_error
);

   localparam int RW = $clog2(NUM_REGS);
   localparam int AW = $clog2(MEM_DEPTH);

   logic [7:0]          reg_mem [NUM_REGS];
   logic [NUM_REGS-1:0] reg_vld_ff;
   logic [7:0]          data_mem [MEM_DEPTH];

   // index extension: pad, then keep exactly the bits the depth needs
   logic [RW+2:0] t_ext, s_ext;
   logic [RW-1:0] t_idx, s_idx;
   logic [AW+7:0] m_ext;
   logic [AW-1:0] m_idx;
   logic          t_ok, s_ok, m_ok;

   assign t_ext = {{RW{1'b0}}, req_target_reg};
   assign s_ext = {{RW{1'b0}}, req_source_reg};
   assign m_ext = {{AW{1'b0}}, req_mem_address};
   assign t_idx = t_ext[RW-1:0];
   assign s_idx = s_ext[RW-1:0];
   assign m_idx = m_ext[AW-1:0];
   assign t_ok  = 32'(req_target_reg) < NUM_REGS;
   assign s_ok  = 32'(req_source_reg) < NUM_REGS;
   assign m_ok  = 32'(req_mem_address) < MEM_DEPTH;

   // captured command fields
   logic [3:0]    cmd_ff;
   logic [RW-1:0] tgt_idx_ff;
   logic          tgt_ok_ff;
   logic          use_src_ff;
   logic [7:0]    imm_ff;
   logic          dir_ff;
   logic [7:0]    amt_ff;
   logic [AW-1:0] maddr_ff;
   logic          addr_ok_ff;
   logic [7:0]    rd_a_ff, rd_s_ff, mem_rd_ff;

   // working result
   logic [7:0]  res_ff, res_in;
   logic [15:0] rem_ff, rem_in;
   logic        carry_ff, carry_in;
   logic        wr_ff, wr_in;
   logic        fupd_ff, fupd_in;
   logic        rupd_ff, rupd_in;
   logic        err_ff, err_in;

   // architectural flag and remainder state
   logic [2:0]  flag_ff, flag_in, flag_new;
   logic [15:0] remst_ff, remst_in;

   logic [7:0]  b_op;
   logic [8:0]  sum9, diff9, inc9;
   logic [15:0] prod;
   logic [3:0]  k_sat;
   logic [16:0] shl;
   logic [8:0]  shr;
   logic [9:0]  trial;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff     <= req_command;
         tgt_idx_ff <= t_idx;
         tgt_ok_ff  <= t_ok;
         use_src_ff <= req_use_source;
         imm_ff     <= req_immediate_value;
         dir_ff     <= req_direction;
         amt_ff     <= req_shift_amount;
         maddr_ff   <= m_idx;
         addr_ok_ff <= m_ok;
         rd_a_ff    <= (t_ok && reg_vld_ff[t_idx]) ? reg_mem[t_idx] : 8'd0;
         rd_s_ff    <= (s_ok && reg_vld_ff[s_idx]) ? reg_mem[s_idx] : 8'd0;
         mem_rd_ff  <= data_mem[m_idx];
      end
   end

   assign b_op     = use_src_ff ? rd_s_ff : imm_ff;
   assign need_div = (cmd_ff == CMD_DIV) && (b_op != 8'd0);

   assign sum9  = {1'b0, rd_a_ff} + {1'b0, b_op};
   assign diff9 = {1'b0, rd_a_ff} - {1'b0, b_op};
   assign inc9  = {1'b0, rd_a_ff} + 9'd1;
   assign prod  = 16'(rd_a_ff) * 16'(b_op);
   // nine or more shifts give the same byte and carry as nine
   assign k_sat = (amt_ff > 8'd8) ? 4'd9 : amt_ff[3:0];
   assign shl   = {9'd0, rd_a_ff} << k_sat;
   assign shr   = {rd_a_ff, 1'b0} >> k_sat;
   assign trial = {1'b0, rem_ff[7:0], res_ff[7]} - {2'b0, b_op};

   always_comb begin
      res_in   = res_ff;
      rem_in   = rem_ff;
      carry_in = carry_ff;
      wr_in    = wr_ff;
      fupd_in  = fupd_ff;
      rupd_in  = rupd_ff;
      err_in   = err_ff;
      if (cmd.exec) begin
         res_in   = rd_a_ff;
         rem_in   = '0;
         carry_in = 1'b0;
         wr_in    = 1'b0;
         fupd_in  = 1'b0;
         rupd_in  = 1'b0;
         err_in   = 1'b0;
         unique case (cmd_ff)
            CMD_MOVE: begin
               res_in = b_op;
               wr_in  = 1'b1;
            end
            CMD_ADD: begin
               res_in   = sum9[7:0];
               carry_in = sum9[8];
               wr_in    = 1'b1;
               fupd_in  = 1'b1;
               rupd_in  = 1'b1;
            end
            CMD_SUB: begin
               res_in   = diff9[7:0];
               carry_in = diff9[8];
               wr_in    = 1'b1;
               fupd_in  = 1'b1;
               rupd_in  = 1'b1;
            end
            CMD_MUL: begin
               res_in   = prod[7:0];
               carry_in = |prod[15:8];
               rem_in   = {prod[15:8], 8'd0};
               wr_in    = 1'b1;
               fupd_in  = 1'b1;
               rupd_in  = 1'b1;
            end
            CMD_DIV: begin
               // res holds the dividend, rem the partial remainder
               if (b_op == 8'd0) begin
                  err_in = 1'b1;
               end else begin
                  wr_in   = 1'b1;
                  fupd_in = 1'b1;
                  rupd_in = 1'b1;
               end
            end
            CMD_AND: begin
               res_in  = rd_a_ff & b_op;
               wr_in   = 1'b1;
               fupd_in = 1'b1;
               rupd_in = 1'b1;
            end
            CMD_OR: begin
               res_in  = rd_a_ff | b_op;
               wr_in   = 1'b1;
               fupd_in = 1'b1;
               rupd_in = 1'b1;
            end
            CMD_XOR: begin
               res_in  = rd_a_ff ^ b_op;
               wr_in   = 1'b1;
               fupd_in = 1'b1;
               rupd_in = 1'b1;
            end
            CMD_XNOR: begin
               res_in  = ~(rd_a_ff ^ b_op);
               wr_in   = 1'b1;
               fupd_in = 1'b1;
               rupd_in = 1'b1;
            end
            CMD_NEGATE: begin
               res_in = 8'd0 - rd_a_ff;
               wr_in  = 1'b1;
            end
            CMD_SHIFT: begin
               if (amt_ff != 8'd0) begin
                  wr_in   = 1'b1;
                  fupd_in = 1'b1;
                  if (dir_ff) begin
                     res_in   = shl[7:0];
                     carry_in = shl[8];
                  end else begin
                     res_in   = shr[8:1];
                     carry_in = shr[0];
                  end
               end
            end
            CMD_COUNT: begin
               wr_in   = 1'b1;
               fupd_in = 1'b1;
               rupd_in = 1'b1;
               if (dir_ff) begin
                  res_in   = inc9[7:0];
                  carry_in = inc9[8];
               end else begin
                  res_in   = diff9[7:0] + b_op - 8'd1;
                  carry_in = (rd_a_ff == 8'd0);
               end
            end
            CMD_LOAD: begin
               res_in = addr_ok_ff ? mem_rd_ff : 8'd0;
               wr_in  = 1'b1;
            end
            default: begin
               // read, save and unused codes leave registers and flags alone
            end
         endcase
      end else if (cmd.div_step) begin
         if (!trial[9]) begin
            rem_in = {8'd0, trial[7:0]};
            res_in = {res_ff[6:0], 1'b1};
         end else begin
            rem_in = {8'd0, rem_ff[6:0], res_ff[7]};
            res_in = {res_ff[6:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      rem_ff   <= rem_in;
      carry_ff <= carry_in;
      wr_ff    <= wr_in;
      fupd_ff  <= fupd_in;
      rupd_ff  <= rupd_in;
      err_ff   <= err_in;
   end

   always_comb begin
      flag_new              = '0;
      flag_new[FLAG_CARRY]  = carry_ff;
      flag_new[FLAG_ZERO]   = (res_ff == 8'd0);
      flag_new[FLAG_PARITY] = ~^res_ff;
      flag_in  = (cmd.commit && fupd_ff) ? flag_new : flag_ff;
      remst_in = (cmd.commit && rupd_ff) ? rem_ff : remst_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff    <= '0;
         remst_ff   <= '0;
         reg_vld_ff <= '0;
      end else begin
         flag_ff  <= flag_in;
         remst_ff <= remst_in;
         if (cmd.commit && wr_ff && tgt_ok_ff) begin
            reg_vld_ff[tgt_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_ff && tgt_ok_ff) begin
         reg_mem[tgt_idx_ff] <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && (cmd_ff == CMD_SAVE) && addr_ok_ff) begin
         data_mem[maddr_ff] <= rd_s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_value         <= wr_ff ? (tgt_ok_ff ? res_ff : 8'd0) : rd_a_ff;
         rsp_flag_bits     <= flag_in;
         rsp_remainder_out <= remst_in;
         rsp_div_error     <= err_ff;
      end
   end

endmodule

`default_nettype wire
